[rtl/stalloc_pkg.sv]
`default_nettype none
package stalloc_pkg;

  localparam int ADDR_W = 25;
  localparam int CALC_W = ADDR_W + 2;
  localparam logic [13:0] BASE_SPAN = 14'd10001;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_ACCESS  = 2'd1;
  localparam logic [1:0] CMD_DESTROY = 2'd2;
  localparam logic [1:0] CMD_COMPACT = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FAULT    = 2'd1;
  localparam logic [1:0] STAT_OVERLOAD = 2'd2;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_MOVE   = 1'b1;

  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_MEMORY_SIZE = 1'b1;

  localparam logic POLICY_FIRST = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_PROC, S_MOVE, S_DONE, S_INSERT, S_ANSWER
  } state_t;

  typedef enum logic [2:0] {
    PH_FIT, PH_COMPACT, PH_NUM, PH_SHIFT, PH_ACCESS, PH_DESTROY
  } phase_t;

  typedef struct packed {
    logic [15:0]       owner;
    logic [5:0]        number;
    logic [13:0]       lbase;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [19:0] addr;
    logic [13:0] base;
    logic [5:0]  num;
    logic [19:0] src;
    logic [20:0] len;
    logic        last;
  } result_t;

  function automatic logic [13:0] fold_base(input logic [13:0] b);
    return (b >= BASE_SPAN) ? b - BASE_SPAN : b;
  endfunction

endpackage
`default_nettype wire

[rtl/segment_table_allocator.sv]
// each pass over the segment table reads an entry (S_READ), then processes or updates it (S_PROC)
// create: fit, numbering and shift passes, then an insert; a failed fit adds a compaction pass
// that emits move results and can stall on the output; create on a full table goes straight to the answer
// access check: one pass that stops at the match; destroy: one pass; compact: one pass plus moves and stalls
// commands: one at a time, the next accepted while the answer waits in the output register
// reset: synchronous, clears the table count (table empty) and sets first fit and full memory
`default_nettype none
module segment_table_allocator
  import stalloc_pkg::*;
#(
  parameter int SEGMENT_SLOTS = 32,
  parameter int MAX_MEMORY_BYTES = 1048576
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // process_id, segment_base, offset, length
  input  wire logic [1:0]  s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,  // status, physical_address, segment_base_res,
                                          // segment_number, move_source, move_length
  output logic [0:0]       m_axis_tuser,  // result_kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [20:0] cfg_data
);

  logic fit_policy;
  logic [20:0] memory_size;
  logic out_free, res_load;
  result_t res, out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POLICY_FIRST;
      memory_size <= 21'd1048576;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIT_POLICY:  fit_policy <= cfg_data[0];
        REG_MEMORY_SIZE: memory_size <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  stalloc_ctrl #(
    .SEGMENT_SLOTS(SEGMENT_SLOTS),
    .MAX_MEMORY_BYTES(MAX_MEMORY_BYTES)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .fit_policy(fit_policy), .memory_size(memory_size),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_command(s_axis_tuser),
    .in_process_id(s_axis_tdata[15:0]),
    .in_segment_base(s_axis_tdata[29:16]),
    .in_offset(s_axis_tdata[50:30]),
    .in_length(s_axis_tdata[71:51]),
    .out_free(out_free), .res_load(res_load), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_reg <= res;
    end
  end

  assign m_axis_tdata = {5'd0, out_reg.len, out_reg.src, out_reg.num, out_reg.base,
                         out_reg.addr, out_reg.status};
  assign m_axis_tuser = out_reg.kind;
  assign m_axis_tlast = out_reg.last;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free) else $error("result loaded over a pending transaction");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice without processing");
  a_move_not_last: assert property (@(posedge clk) disable iff (rst)
    res_load && res.kind == KIND_MOVE |-> !res.last) else $error("move marked last");
  a_answer_last: assert property (@(posedge clk) disable iff (rst)
    res_load && res.kind == KIND_ANSWER |-> res.last) else $error("answer not marked last");
`endif

endmodule
`default_nettype wire

[rtl/stalloc_mem.sv]
`default_nettype none
module stalloc_mem
  import stalloc_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int IW = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [IW-1:0] raddr,
  output entry_t             rdata
);

  entry_t ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= ram[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/stalloc_ctrl.sv]
`default_nettype none
module stalloc_ctrl
  import stalloc_pkg::*;
#(
  parameter int SEGMENT_SLOTS = 32,
  parameter int MAX_MEMORY_BYTES = 1048576
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fit_policy,
  input  wire logic [20:0] memory_size,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_process_id,
  input  wire logic [13:0] in_segment_base,
  input  wire logic [20:0] in_offset,
  input  wire logic [20:0] in_length,
  input  wire logic        out_free,
  output logic             res_load,
  output result_t          res
);

  localparam int IW = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
  localparam int CNTW = $clog2(SEGMENT_SLOTS + 1);
  localparam logic [CNTW-1:0] SLOTS_C = CNTW'(SEGMENT_SLOTS);
  localparam logic [CALC_W-1:0] MAX_C = CALC_W'(MAX_MEMORY_BYTES);

  state_t state, state_next;
  phase_t phase;
  logic [CNTW-1:0] count, idx, wj, at;
  logic at_found, have, found;
  logic [CALC_W-1:0] cursor, pos;
  logic signed [CALC_W-1:0] best;
  logic [6:0] num;
  logic [1:0] cmd;
  logic [15:0] pid;
  logic [13:0] base;
  logic [20:0] off, len;
  logic [1:0] ans_status;
  logic [19:0] ans_addr;
  logic [13:0] ans_base;
  logic [5:0] ans_num;

  logic mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, e;

  stalloc_mem #(.DEPTH(SEGMENT_SLOTS), .IW(IW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(e)
  );

  logic [CALC_W-1:0] mem_c, len_c, e_start, e_len, e_end, acc_sum;
  logic signed [CALC_W-1:0] gap, tail, best_f;
  logic at_end, hole_fits, wf_take, fit_ok, cmp_ok, match, acc_fault, moved, accept;
  logic [CALC_W-1:0] fit_pos;

  assign mem_c = (CALC_W'(memory_size) > MAX_C) ? MAX_C : CALC_W'(memory_size);
  assign len_c = CALC_W'(len);
  assign e_start = CALC_W'(e.start);
  assign e_len = CALC_W'(e.length);
  assign e_end = e_start + e_len;
  assign gap = $signed(e_start) - $signed(cursor);
  assign tail = $signed(mem_c) - $signed(cursor);
  assign hole_fits = $signed(len_c) <= gap;
  assign wf_take = !have || (tail > best);
  assign best_f = wf_take ? tail : best;
  assign fit_ok = (fit_policy == POLICY_FIRST) ? (found || ($signed(len_c) <= tail))
                                               : (best_f >= $signed(len_c));
  assign fit_pos = (fit_policy == POLICY_FIRST) ? (found ? pos : cursor)
                                                : (wf_take ? cursor : pos);
  assign cmp_ok = $signed(len_c) <= tail;
  assign match = (e.owner == pid) && (e.lbase == base);
  assign acc_sum = CALC_W'(off) + CALC_W'(len);
  assign acc_fault = acc_sum > e_len;
  assign moved = e_start != cursor;
  assign at_end = (phase == PH_SHIFT) ? (idx == at) : (idx == count);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_CREATE && count >= SLOTS_C) state_next = S_ANSWER;
          else state_next = S_READ;
        end
      end
      S_READ: state_next = at_end ? S_DONE : S_PROC;
      S_PROC: begin
        state_next = S_READ;
        if (phase == PH_FIT && fit_policy == POLICY_FIRST && hole_fits) state_next = S_DONE;
        if (phase == PH_COMPACT && moved) state_next = S_MOVE;
        if (phase == PH_ACCESS && match) state_next = S_ANSWER;
      end
      S_MOVE: state_next = out_free ? S_READ : S_MOVE;
      S_DONE: begin
        unique case (phase)
          PH_FIT:     state_next = S_READ;
          PH_COMPACT: state_next = (cmd == CMD_CREATE && cmp_ok) ? S_READ : S_ANSWER;
          PH_NUM:     state_next = S_READ;
          PH_SHIFT:   state_next = S_INSERT;
          default:    state_next = S_ANSWER;
        endcase
      end
      S_INSERT: state_next = S_ANSWER;
      S_ANSWER: state_next = out_free ? S_IDLE : S_ANSWER;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == S_IDLE;
    mem_re = (state == S_READ) && !at_end;
    mem_raddr = (phase == PH_SHIFT) ? IW'(idx - 1'b1) : idx[IW-1:0];
    mem_we = 1'b0;
    mem_waddr = idx[IW-1:0];
    mem_wdata = e;
    if (state == S_PROC) begin
      if (phase == PH_COMPACT && moved) begin
        mem_we = 1'b1;
        mem_wdata.start = cursor[ADDR_W-1:0];
      end
      if (phase == PH_SHIFT) mem_we = 1'b1;
      if (phase == PH_DESTROY && e.owner != pid) begin
        mem_we = 1'b1;
        mem_waddr = wj[IW-1:0];
      end
    end
    if (state == S_INSERT) begin
      mem_we = 1'b1;
      mem_waddr = at[IW-1:0];
      mem_wdata.owner = pid;
      mem_wdata.number = num[5:0];
      mem_wdata.lbase = base;
      mem_wdata.length = len_c[ADDR_W-1:0];
      mem_wdata.start = pos[ADDR_W-1:0];
    end
    res = '0;
    res_load = 1'b0;
    if (state == S_MOVE) begin
      res_load = out_free;
      res.kind = KIND_MOVE;
      res.status = STAT_OK;
      res.addr = cursor[19:0];
      res.src = e.start[19:0];
      res.len = e.length[20:0];
    end
    if (state == S_ANSWER) begin
      res_load = out_free;
      res.kind = KIND_ANSWER;
      res.status = ans_status;
      res.addr = ans_addr;
      res.base = ans_base;
      res.num = ans_num;
      res.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_FIT;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd <= in_command;
            pid <= in_process_id;
            base <= fold_base(in_segment_base);
            off <= in_offset;
            len <= in_length;
            idx <= '0;
            wj <= '0;
            cursor <= '0;
            have <= 1'b0;
            found <= 1'b0;
            ans_status <= STAT_OVERLOAD;
            ans_addr <= '0;
            ans_base <= '0;
            ans_num <= '0;
            unique case (in_command)
              CMD_CREATE:  phase <= PH_FIT;
              CMD_ACCESS:  phase <= PH_ACCESS;
              CMD_DESTROY: phase <= PH_DESTROY;
              default:     phase <= PH_COMPACT;
            endcase
          end
        end
        S_PROC: begin
          unique case (phase)
            PH_FIT: begin
              if (fit_policy == POLICY_FIRST) begin
                if (hole_fits) begin
                  found <= 1'b1;
                  pos <= cursor;
                end else begin
                  cursor <= e_end;
                  idx <= idx + 1'b1;
                end
              end else begin
                if (!have || gap > best) begin
                  best <= gap;
                  pos <= cursor;
                  have <= 1'b1;
                end
                cursor <= e_end;
                idx <= idx + 1'b1;
              end
            end
            PH_COMPACT: begin
              if (!moved) begin
                cursor <= e_end;
                idx <= idx + 1'b1;
              end
            end
            PH_NUM: begin
              if (e.owner == pid && {1'b0, e.number} >= num) num <= {1'b0, e.number} + 7'd1;
              if (!at_found && e_start > pos) begin
                at <= idx;
                at_found <= 1'b1;
              end
              idx <= idx + 1'b1;
            end
            PH_SHIFT: idx <= idx - 1'b1;
            PH_ACCESS: begin
              if (match) begin
                ans_status <= acc_fault ? STAT_FAULT : STAT_OK;
                ans_addr <= acc_fault ? 20'd0 : 20'(e_start + CALC_W'(off));
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: begin
              if (e.owner != pid) wj <= wj + 1'b1;
              idx <= idx + 1'b1;
            end
          endcase
        end
        S_MOVE: begin
          if (out_free) begin
            cursor <= cursor + e_len;
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          unique case (phase)
            PH_FIT: begin
              idx <= '0;
              if (fit_ok) begin
                phase <= PH_NUM;
                pos <= fit_pos;
                num <= '0;
                at <= count;
                at_found <= 1'b0;
              end else begin
                phase <= PH_COMPACT;
                cursor <= '0;
              end
            end
            PH_COMPACT: begin
              if (cmd == CMD_CREATE) begin
                if (cmp_ok) begin
                  phase <= PH_NUM;
                  idx <= '0;
                  pos <= cursor;
                  num <= '0;
                  at <= count;
                  at_found <= 1'b0;
                end
              end else begin
                ans_status <= STAT_OK;
                ans_addr <= cursor[19:0];
              end
            end
            PH_NUM: begin
              phase <= PH_SHIFT;
              idx <= count;
            end
            PH_SHIFT: ;
            PH_ACCESS: ans_status <= STAT_FAULT;
            default: begin
              count <= wj;
              ans_status <= STAT_OK;
            end
          endcase
        end
        S_INSERT: begin
          count <= count + 1'b1;
          ans_status <= STAT_OK;
          ans_addr <= pos[19:0];
          ans_base <= base;
          ans_num <= num[5:0];
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
